/* hdl/cvt_pkg.sv */
// Package for the camera view transform: shared widths, register codes and the
// configuration and scale-status structs. No dependencies.
package cvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PPU_W     = 46;    // pixels per unit, FRAC_BITS fraction bits
    localparam int QUOT_W    = 48;    // screen-to-world dividend / quotient width
    localparam logic [31:0] ZOOM_MIN = 32'((1 << FRAC_BITS) / 100);

    typedef enum logic [2:0] {
        REG_VIEW_W   = 3'd0,
        REG_VIEW_H   = 3'd1,
        REG_DESIGN_W = 3'd2,
        REG_DESIGN_H = 3'd3,
        REG_ZOOM     = 3'd4,
        REG_INT_SCL  = 3'd5,
        REG_COS      = 3'd6,
        REG_SIN      = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [13:0]        view_width;
        logic [13:0]        view_height;
        logic [15:0]        design_width;
        logic [15:0]        design_height;
        logic [31:0]        zoom_factor;
        logic               whole_scale;
        logic signed [15:0] rotation_cosine;
        logic signed [15:0] rotation_sine;
    } t_cfg;

    typedef struct packed {
        logic [PPU_W-1:0] ppu;
        logic             zero;   // scale floored to zero, raised to one LSB
        logic             busy;
    } t_scale_stat;

endpackage

/* hdl/cvt_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// No dependencies; divisor must stay constant while items are in flight.
module cvt_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 46,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic [DEN_W-1:0]  r_rem  [1:NUM_W-1];
    logic [NUM_W-1:0]  r_num  [1:NUM_W-1];
    logic [NUM_W-1:0]  r_quo  [1:NUM_W];
    logic [SIDE_W-1:0] r_side [1:NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [NUM_W-1:0]  num_in;
        logic [NUM_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign num_in  = i_num;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k];
            assign num_in  = r_num[k];
            assign quo_in  = r_quo[k];
            assign side_in = r_side[k];
        end

        assign trial = {rem_in, num_in[NUM_W-1]};
        assign ge    = trial >= {1'b0, i_den};

        if (k < NUM_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= ge ? DEN_W'(trial - {1'b0, i_den}) : trial[DEN_W-1:0];
                r_num[k+1] <= num_in << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_quo[k+1]  <= {quo_in[NUM_W-2:0], ge};
            r_side[k+1] <= side_in;
        end
    end

    assign o_quot = r_quo[NUM_W];
    assign o_side = r_side[NUM_W];

endmodule

/* hdl/cvt_scale.sv */
// Pixels-per-unit sequencer: two serial ratio divisions, one multiply, floor.
// Depends on cvt_pkg (t_cfg, t_scale_stat, widths).
module cvt_scale import cvt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_cfg        i_cfg,
    output t_scale_stat o_stat
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_DIVX, ST_DIVY, ST_MUL, ST_FIN
    } t_state;

    localparam int RAT_W = 14 + FRAC_BITS;
    localparam logic [4:0] CNT_LAST = 5'(RAT_W - 1);

    t_state             r_state;
    logic [4:0]         r_cnt;
    logic [RAT_W-1:0]   r_num;
    logic [15:0]        r_den;
    logic [15:0]        r_rem;
    logic [RAT_W-1:0]   r_quo;
    logic [RAT_W-1:0]   r_ratio;
    logic [RAT_W+31:0]  r_prod;
    logic [PPU_W-1:0]   r_ppu;
    logic               r_zero;

    logic [16:0]        trial;
    logic               ge;
    logic [15:0]        n_rem;
    logic [RAT_W-1:0]   n_quo;
    logic [31:0]        zoom;
    logic [15:0]        dw1, dh1;
    logic [PPU_W-1:0]   n_ppu;
    logic               n_zero;

    assign trial = {r_rem, r_num[RAT_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign n_rem = ge ? 16'(trial - {1'b0, r_den}) : trial[15:0];
    assign n_quo = {r_quo[RAT_W-2:0], ge};
    assign zoom  = (i_cfg.zoom_factor < ZOOM_MIN) ? ZOOM_MIN : i_cfg.zoom_factor;
    assign dw1   = (i_cfg.design_width  == 16'd0) ? 16'd1 : i_cfg.design_width;
    assign dh1   = (i_cfg.design_height == 16'd0) ? 16'd1 : i_cfg.design_height;

    always_comb begin
        n_ppu = r_prod[FRAC_BITS +: PPU_W];
        if (i_cfg.whole_scale) begin
            n_ppu[FRAC_BITS-1:0] = '0;
            if (n_ppu[PPU_W-1:FRAC_BITS] == '0) begin
                n_ppu = PPU_W'(1) << FRAC_BITS;
            end
        end
        n_zero = (n_ppu == '0);
        if (n_zero) begin
            n_ppu = PPU_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else if (i_start) begin
            r_state <= ST_LOAD;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_state <= ST_IDLE;
                end
                ST_LOAD: begin
                    r_num   <= {i_cfg.view_width, FRAC_BITS'(0)};
                    r_den   <= dw1;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIVX;
                end
                ST_DIVX: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == CNT_LAST) begin
                        r_ratio <= n_quo;
                        r_num   <= {i_cfg.view_height, FRAC_BITS'(0)};
                        r_den   <= dh1;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIVY;
                    end
                end
                ST_DIVY: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == CNT_LAST) begin
                        r_ratio <= (n_quo < r_ratio) ? n_quo : r_ratio;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= (RAT_W+32)'(r_ratio) * (RAT_W+32)'(zoom);
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_ppu   <= n_ppu;
                    r_zero  <= n_zero;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stat.ppu  = r_ppu;
    assign o_stat.zero = r_zero;
    assign o_stat.busy = (r_state != ST_IDLE);

endmodule

/* hdl/camera_view_transform.sv */
// Top level of the camera view transform: config registers, item pipeline.
// Depends on cvt_pkg, cvt_scale (pixels-per-unit) and cvt_div (divider).
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-------------------------------
//  command   | in        | i_start, o_busy      | i_kind, i_point_x/y, i_center_x/y
//  result    | out       | o_valid (strobe)     | o_out_x, o_out_y, o_saturated
//  config    | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One transfer per cycle is accepted (start high, busy low); its result strobes
// once it has passed 55 registers in line, the first loaded by the accepting
// edge: one entry stage, 48 divider stages (one quotient bit each), then
// operand, two rotation, two scaling stages and the output register.
// After reset busy stays high while cvt_scale recomputes pixels per unit
// (load, two 30-step serial divisions, multiply, final); after a config write
// the registered write flag also holds it high. The receiver cannot stall;
// results just flow.
module camera_view_transform import cvt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_kind,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    output logic               o_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    localparam int DIV_N = QUOT_W;
    localparam logic [QUOT_W-1:0] QUOT_LIM = QUOT_W'(1) << 46;

    // sideband that rides through the x divider
    typedef struct packed {
        logic               kind;
        logic signed [32:0] dx;      // world-to-screen point minus center
        logic signed [32:0] dy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               sgn_x;   // sign of point minus half view
    } t_side;

    typedef struct packed {
        logic               kind;
        logic signed [47:0] a;
        logic signed [47:0] b;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               flag;
    } t_opnd;

    typedef struct packed {
        logic               kind;
        logic signed [64:0] ca, sb, sa, cb;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               flag;
    } t_prod;

    typedef struct packed {
        logic               kind;
        logic signed [53:0] rx;
        logic signed [53:0] ry;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               flag;
    } t_rot;

    typedef struct packed {
        logic               kind;
        logic signed [53:0] rx;
        logic signed [53:0] ry;
        logic [58:0]        plx, phx, ply, phy;
        logic               negx, negy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               flag;
    } t_up;

    typedef struct packed {
        logic signed [63:0] v;
        logic               ovf;
    } t_fin;

    // ---------------- helpers ----------------
    // base + floor(+-p / 2^FRAC_BITS), folded into one add after the partial
    // product sum; huge products clip to base +- 2^40
    function automatic t_fin up_fin(input logic [58:0] pl, input logic [58:0] ph,
                                    input logic neg, input logic signed [63:0] base);
        t_fin               res;
        logic [81:0]        full;
        logic [81:0]        p;
        logic signed [81:0] acc;
        full    = 82'(pl) + (82'(ph) << 23);
        p       = {19'b0, full[62:0]};
        res.ovf = full > (82'd1 << 62);
        acc     = (82'(base) << FRAC_BITS) + (neg ? ~p : p) + {81'b0, neg};
        if (res.ovf) begin
            res.v = neg ? base - (64'sd1 <<< 40) : base + (64'sd1 <<< 40);
        end else begin
            res.v = 64'(acc >>> FRAC_BITS);
        end
        return res;
    endfunction

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] res;
        if (v > 64'sd2147483647) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    // ---------------- configuration ----------------
    t_cfg        r_cfg;
    logic        r_wr;
    t_scale_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_width      <= 14'd640;
            r_cfg.view_height     <= 14'd480;
            r_cfg.design_width    <= 16'd640;
            r_cfg.design_height   <= 16'd480;
            r_cfg.zoom_factor     <= 32'd65536;
            r_cfg.whole_scale     <= 1'b0;
            r_cfg.rotation_cosine <= 16'sd16384;
            r_cfg.rotation_sine   <= 16'sd0;
            r_wr                  <= 1'b0;
        end else begin
            r_wr <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_VIEW_W:   r_cfg.view_width      <= i_cfg_data[13:0];
                    REG_VIEW_H:   r_cfg.view_height     <= i_cfg_data[13:0];
                    REG_DESIGN_W: r_cfg.design_width    <= i_cfg_data[15:0];
                    REG_DESIGN_H: r_cfg.design_height   <= i_cfg_data[15:0];
                    REG_ZOOM:     r_cfg.zoom_factor     <= i_cfg_data;
                    REG_INT_SCL:  r_cfg.whole_scale     <= i_cfg_data[0];
                    REG_COS:      r_cfg.rotation_cosine <= $signed(i_cfg_data[15:0]);
                    REG_SIN:      r_cfg.rotation_sine   <= $signed(i_cfg_data[15:0]);
                    default:      r_cfg.view_width      <= r_cfg.view_width;
                endcase
            end
        end
    end

    // recompute scale in the cycle after a write, once the register holds it
    cvt_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_wr),
        .i_cfg   (r_cfg),
        .o_stat  (w_stat)
    );

    assign o_busy = w_stat.busy | r_wr;

    logic               w_acc;
    logic signed [32:0] w_hx33, w_hy33;
    logic signed [32:0] w_ex, w_ey;
    logic signed [63:0] w_hx, w_hy;

    assign w_acc  = i_start & ~o_busy;
    assign w_hx33 = $signed({4'b0, r_cfg.view_width,  15'b0});
    assign w_hy33 = $signed({4'b0, r_cfg.view_height, 15'b0});
    assign w_hx   = $signed({35'b0, r_cfg.view_width,  15'b0});
    assign w_hy   = $signed({35'b0, r_cfg.view_height, 15'b0});
    assign w_ex   = 33'(i_point_x) - w_hx33;
    assign w_ey   = 33'(i_point_y) - w_hy33;

    // ---------------- entry stage ----------------
    logic              r1_vld;
    t_side             r1_side;
    logic              r1_sgn_y;
    logic [QUOT_W-1:0] r1_num_x, r1_num_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= w_acc;
        end
        r1_side.kind  <= i_kind;
        r1_side.dx    <= 33'(i_point_x) - 33'(i_center_x);
        r1_side.dy    <= 33'(i_point_y) - 33'(i_center_y);
        r1_side.cx    <= i_center_x;
        r1_side.cy    <= i_center_y;
        r1_side.sgn_x <= w_ex[32];
        r1_sgn_y      <= w_ey[32];
        r1_num_x      <= {(w_ex[32] ? 32'(-w_ex) : 32'(w_ex)), FRAC_BITS'(0)};
        r1_num_y      <= {(w_ey[32] ? 32'(-w_ey) : 32'(w_ey)), FRAC_BITS'(0)};
    end

    // ---------------- divider ----------------
    logic [DIV_N-1:0]  r_vld_div;
    logic [QUOT_W-1:0] w_qx, w_qy;
    t_side             w_side;
    logic              w_sgn_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_div <= '0;
        end else begin
            r_vld_div <= {r_vld_div[DIV_N-2:0], r1_vld};
        end
    end

    cvt_div #(.NUM_W(QUOT_W), .DEN_W(PPU_W), .SIDE_W($bits(t_side))) u_div_x (
        .i_clk  (i_clk),
        .i_num  (r1_num_x),
        .i_den  (w_stat.ppu),
        .i_side (r1_side),
        .o_quot (w_qx),
        .o_side (w_side)
    );

    cvt_div #(.NUM_W(QUOT_W), .DEN_W(PPU_W), .SIDE_W(1)) u_div_y (
        .i_clk  (i_clk),
        .i_num  (r1_num_y),
        .i_den  (w_stat.ppu),
        .i_side (r1_sgn_y),
        .o_quot (w_qy),
        .o_side (w_sgn_y)
    );

    // ---------------- rotation operands ----------------
    logic              w_clx, w_cly;
    logic [QUOT_W-1:0] w_mqx, w_mqy;
    logic              rq_vld;
    t_opnd             rq;

    assign w_clx = w_qx > QUOT_LIM;
    assign w_cly = w_qy > QUOT_LIM;
    assign w_mqx = w_clx ? QUOT_LIM : w_qx;
    assign w_mqy = w_cly ? QUOT_LIM : w_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rq_vld <= 1'b0;
        end else begin
            rq_vld <= r_vld_div[DIV_N-1];
        end
        rq.kind <= w_side.kind;
        rq.cx   <= w_side.cx;
        rq.cy   <= w_side.cy;
        if (w_side.kind) begin
            rq.a    <= w_side.sgn_x ? -$signed(w_mqx) : $signed(w_mqx);
            rq.b    <= w_sgn_y      ? -$signed(w_mqy) : $signed(w_mqy);
            rq.flag <= w_clx | w_cly;
        end else begin
            rq.a    <= 48'(w_side.dx);
            rq.b    <= 48'(w_side.dy);
            rq.flag <= 1'b0;
        end
    end

    // ---------------- rotation products ----------------
    // world to screen turns by minus the angle: sine enters negated
    logic signed [16:0] w_c, w_s;
    logic               rr1_vld;
    t_prod              rr1;

    assign w_c = 17'(r_cfg.rotation_cosine);
    assign w_s = rq.kind ? 17'(r_cfg.rotation_sine) : -17'(r_cfg.rotation_sine);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rr1_vld <= 1'b0;
        end else begin
            rr1_vld <= rq_vld;
        end
        rr1.kind <= rq.kind;
        rr1.ca   <= 65'(w_c) * 65'(rq.a);
        rr1.sb   <= 65'(w_s) * 65'(rq.b);
        rr1.sa   <= 65'(w_s) * 65'(rq.a);
        rr1.cb   <= 65'(w_c) * 65'(rq.b);
        rr1.cx   <= rq.cx;
        rr1.cy   <= rq.cy;
        rr1.flag <= rq.flag;
    end

    // ---------------- rotation sums, Q2.14 round half up ----------------
    logic  rr2_vld;
    t_rot  rr2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rr2_vld <= 1'b0;
        end else begin
            rr2_vld <= rr1_vld;
        end
        rr2.kind <= rr1.kind;
        rr2.rx   <= 54'((67'(rr1.ca) - 67'(rr1.sb) + 67'sd8192) >>> 14);
        rr2.ry   <= 54'((67'(rr1.sa) + 67'(rr1.cb) + 67'sd8192) >>> 14);
        rr2.cx   <= rr1.cx;
        rr2.cy   <= rr1.cy;
        rr2.flag <= rr1.flag;
    end

    // ---------------- scale-up partial products ----------------
    logic [35:0] w_magx, w_magy;
    logic        ru1_vld;
    t_up         ru1;

    assign w_magx = rr2.rx[53] ? 36'(-rr2.rx) : 36'(rr2.rx);
    assign w_magy = rr2.ry[53] ? 36'(-rr2.ry) : 36'(rr2.ry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ru1_vld <= 1'b0;
        end else begin
            ru1_vld <= rr2_vld;
        end
        ru1.kind <= rr2.kind;
        ru1.rx   <= rr2.rx;
        ru1.ry   <= rr2.ry;
        ru1.plx  <= 59'(w_magx) * 59'(w_stat.ppu[22:0]);
        ru1.phx  <= 59'(w_magx) * 59'(w_stat.ppu[45:23]);
        ru1.ply  <= 59'(w_magy) * 59'(w_stat.ppu[22:0]);
        ru1.phy  <= 59'(w_magy) * 59'(w_stat.ppu[45:23]);
        ru1.negx <= rr2.rx[53];
        ru1.negy <= rr2.ry[53];
        ru1.cx   <= rr2.cx;
        ru1.cy   <= rr2.cy;
        ru1.flag <= rr2.flag;
    end

    // ---------------- final sums ----------------
    t_fin               w_fx, w_fy;
    logic               ru2_vld;
    logic signed [63:0] ru2_x, ru2_y;
    logic               ru2_flag;

    assign w_fx = up_fin(ru1.plx, ru1.phx, ru1.negx, w_hx);
    assign w_fy = up_fin(ru1.ply, ru1.phy, ru1.negy, w_hy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ru2_vld <= 1'b0;
        end else begin
            ru2_vld <= ru1_vld;
        end
        if (ru1.kind) begin
            ru2_x    <= 64'(ru1.cx) + 64'(ru1.rx);
            ru2_y    <= 64'(ru1.cy) + 64'(ru1.ry);
            ru2_flag <= ru1.flag;
        end else begin
            ru2_x    <= w_fx.v;
            ru2_y    <= w_fy.v;
            ru2_flag <= ru1.flag | w_fx.ovf | w_fy.ovf;
        end
    end

    // ---------------- output register, 32-bit clip ----------------
    logic [32:0] w_sx, w_sy;

    assign w_sx = sat32(ru2_x);
    assign w_sy = sat32(ru2_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= ru2_vld;
        end
        o_out_x     <= $signed(w_sx[31:0]);
        o_out_y     <= $signed(w_sy[31:0]);
        o_saturated <= ru2_flag | w_sx[32] | w_sy[32] | w_stat.zero;
    end

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r1_vld)
        else $error("accepted transfer did not enter the pipeline");

    a_div_to_opnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_div[DIV_N-1] |=> rq_vld)
        else $error("divider valid lost");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ru2_vld |=> o_valid)
        else $error("result strobe lost");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_busy)
        else $error("config write did not hold off transfers");
`endif

endmodule

/* sim/camera_view_transform_test.sv */
// Testbench for camera_view_transform: directed corner cases, then random
// points under many register settings, checked against an in-bench predictor.
// Depends on cvt_pkg and the camera_view_transform RTL.
`timescale 1ns / 100ps

module camera_view_transform_test;
    import cvt_pkg::*;

    typedef struct {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               saturated;
    } t_point_result;

    localparam longint FMASK   = (64'd1 << FRAC_BITS) - 1;
    localparam longint Q_BOUND = 64'd1 << 46;
    localparam longint M_BOUND = 64'd1 << 62;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_kind;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [31:0] i_center_x;
    logic signed [31:0] i_center_y;
    logic               o_valid;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic               o_saturated;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;

    t_cfg          view_regs;          // predictor's copy of the registers
    t_point_result expected_points[$]; // predictions awaiting their result
    int            mismatches;
    int            points_sent;
    int            points_checked;
    int            settings_used;
    bit            steady;             // suppresses random gaps on the command side

    camera_view_transform DUT (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // ---------------------------------------------------------------- predictor
    function automatic longint pixels_per_unit(input t_cfg c, inout logic sat);
        longint dw, dh, rx, ry, r, z, p;
        dw = (c.design_width == 0) ? 1 : longint'(c.design_width);
        dh = (c.design_height == 0) ? 1 : longint'(c.design_height);
        rx = (longint'(c.view_width) << FRAC_BITS) / dw;
        ry = (longint'(c.view_height) << FRAC_BITS) / dh;
        r  = (rx < ry) ? rx : ry;
        z  = (c.zoom_factor < ZOOM_MIN) ? longint'(ZOOM_MIN) : longint'(c.zoom_factor);
        p  = r * (z >> FRAC_BITS) + ((r * (z & FMASK)) >> FRAC_BITS);
        if (c.whole_scale) begin
            p = p & ~FMASK;
            if (p < (64'd1 << FRAC_BITS))
                p = 64'd1 << FRAC_BITS;
        end
        if (p == 0) begin
            sat = 1'b1;
            p   = 1;
        end
        return p;
    endfunction

    // rotation in Q2.14, rounded half up (arithmetic shift floors)
    function automatic void rotate_q14(input longint cs, sn, a, b,
                                       output longint oa, ob);
        oa = (cs * a - sn * b + 8192) >>> 14;
        ob = (sn * a + cs * b + 8192) >>> 14;
    endfunction

    function automatic longint scale_to_pixels(input longint d, ppu, inout logic sat);
        longint mag, prod;
        mag = (d < 0) ? -d : d;
        if (mag != 0 && ppu > M_BOUND / mag) begin
            sat = 1'b1;
            return (d < 0) ? -(64'sd1 <<< 40) : (64'sd1 <<< 40);
        end
        prod = mag * ppu;
        return ((d < 0) ? -prod : prod) >>> FRAC_BITS;
    endfunction

    function automatic longint scale_to_units(input longint d, ppu, inout logic sat);
        longint mag, q;
        mag = (d < 0) ? -d : d;
        q   = (mag << FRAC_BITS) / ppu;
        if (q > Q_BOUND) begin
            sat = 1'b1;
            q   = Q_BOUND;
        end
        return (d < 0) ? -q : q;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_point_result predict_point(input t_cfg c, input logic kind,
            input logic signed [31:0] px, py, cx, cy);
        t_point_result res;
        logic   sat;
        longint cs, sn, hx, hy, ppu, rx, ry, dx, dy, ox, oy;
        sat = 1'b0;
        cs  = c.rotation_cosine;
        sn  = c.rotation_sine;
        hx  = longint'(c.view_width) << (FRAC_BITS - 1);
        hy  = longint'(c.view_height) << (FRAC_BITS - 1);
        ppu = pixels_per_unit(c, sat);
        if (kind == 1'b0) begin
            // world to screen: rotate by minus the angle
            rotate_q14(cs, -sn, longint'(px) - cx, longint'(py) - cy, rx, ry);
            ox = hx + scale_to_pixels(rx, ppu, sat);
            oy = hy + scale_to_pixels(ry, ppu, sat);
        end else begin
            dx = scale_to_units(longint'(px) - hx, ppu, sat);
            dy = scale_to_units(longint'(py) - hy, ppu, sat);
            rotate_q14(cs, sn, dx, dy, rx, ry);
            ox = longint'(cx) + rx;
            oy = longint'(cy) + ry;
        end
        res.out_x     = clip32(ox, sat);
        res.out_y     = clip32(oy, sat);
        res.saturated = sat;
        return res;
    endfunction

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_point_result exp_pt;
        if (i_rst_n && o_valid) begin
            if (expected_points.size() == 0) begin
                $error("result with no transfer outstanding: x=%0d y=%0d",
                       o_out_x, o_out_y);
                mismatches++;
            end else begin
                exp_pt = expected_points.pop_front();
                points_checked++;
                if (o_out_x !== exp_pt.out_x) begin
                    $error("out_x: expected %0d, got %0d", exp_pt.out_x, o_out_x);
                    mismatches++;
                end
                if (o_out_y !== exp_pt.out_y) begin
                    $error("out_y: expected %0d, got %0d", exp_pt.out_y, o_out_y);
                    mismatches++;
                end
                if (o_saturated !== exp_pt.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           exp_pt.saturated, o_saturated);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers
    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_point(input logic kind, input logic signed [31:0] px, py, cx, cy);
        if (!steady && $urandom_range(0, 99) < 9) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_start    <= 1'b1;
        i_kind     <= kind;
        i_point_x  <= px;
        i_point_y  <= py;
        i_center_x <= cx;
        i_center_y <= cy;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        expected_points.push_back(predict_point(view_regs, kind, px, py, cx, cy));
        points_sent++;
        @(negedge i_clk);
    endtask

    // Register writes only once every outstanding result has come back.
    task automatic write_register(input t_reg_idx idx, input logic [31:0] data);
        i_start <= 1'b0;
        wait (expected_points.size() == 0);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_VIEW_W:   view_regs.view_width      = data[13:0];
            REG_VIEW_H:   view_regs.view_height     = data[13:0];
            REG_DESIGN_W: view_regs.design_width    = data[15:0];
            REG_DESIGN_H: view_regs.design_height   = data[15:0];
            REG_ZOOM:     view_regs.zoom_factor     = data;
            REG_INT_SCL:  view_regs.whole_scale     = data[0];
            REG_COS:      view_regs.rotation_cosine = data[15:0];
            REG_SIN:      view_regs.rotation_sine   = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_view(input logic [31:0] vw, vh, dw, dh, zoom,
                             input logic iscl, input logic [31:0] cs, sn);
        write_register(REG_VIEW_W, vw);
        write_register(REG_VIEW_H, vh);
        write_register(REG_DESIGN_W, dw);
        write_register(REG_DESIGN_H, dh);
        write_register(REG_ZOOM, zoom);
        write_register(REG_INT_SCL, {31'd0, iscl});
        write_register(REG_COS, cs);
        write_register(REG_SIN, sn);
        settings_used++;
    endtask

    // A random point: fully random, or a small offset from the center / mid-view
    // so that most results stay in range.
    task automatic random_point();
        logic               kind;
        logic signed [31:0] cx, cy, px, py, offx, offy;
        kind = 1'($urandom_range(0, 1));
        cx   = $urandom;
        cy   = $urandom;
        offx = $signed($urandom) >>> $urandom_range(4, 31);
        offy = $signed($urandom) >>> $urandom_range(4, 31);
        case ($urandom_range(0, 3))
            0: begin
                px = $urandom;
                py = $urandom;
            end
            1: begin
                cx = $signed($urandom) >>> $urandom_range(0, 16);
                cy = $signed($urandom) >>> $urandom_range(0, 16);
                px = cx + offx;
                py = cy + offy;
            end
            default: begin
                if (kind) begin
                    px = (view_regs.view_width << 15) + offx;
                    py = (view_regs.view_height << 15) + offy;
                end else begin
                    px = cx + offx;
                    py = cy + offy;
                end
            end
        endcase
        send_point(kind, px, py, cx, cy);
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_reset_defaults();
        send_point(1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_point(1'b0, 32'sh0001_0000, -32'sh0002_8000, 32'sd0, 32'sd0);
        send_point(1'b1, 32'sh0140_0000, 32'sh00f0_0000, 32'sh0010_0000, -32'sd1);
        send_point(1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        settings_used++;
    endtask

    task automatic test_field_extremes();
        // Full-scale points and centers in both directions; several clip.
        send_point(1'b0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_point(1'b0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_point(1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_point(1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_point(1'b0, -32'sd1, -32'sd1, 32'sd0, 32'sd0);
        send_point(1'b1, -32'sd1, 32'sd1, -32'sd1, 32'sd1);
    endtask

    task automatic test_scale_corners();
        // Scale zero: zero view width, ppu raised to one LSB; screen-to-world
        // quotient overflows its bound.
        load_view(0, 480, 640, 480, 65536, 1'b0, 16384, 0);
        send_point(1'b0, 32'sh0001_0000, 32'sd5, 32'sd0, 32'sd0);
        send_point(1'b1, 32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd0);
        send_point(1'b1, 32'sd3, -32'sd3, 32'sd0, 32'sd0);
        // Huge scale: view 8192 by 8192, design one, max zoom; product overflows.
        load_view(8192, 8192, 1, 0, 32'hffffffff, 1'b0, -16384, 16384);
        send_point(1'b0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_point(1'b0, 32'sd1, 32'sd0, 32'sd0, 32'sd0);
        send_point(1'b1, 32'sh0000_0001, 32'sh1000_0000, 32'sd7, -32'sd7);
        // Integer mode with a fractional scale below one; minimum zoom.
        load_view(100, 100, 65535, 65535, 0, 1'b1, 11585, -11585);
        send_point(1'b0, 32'sh0123_4567, -32'sh0765_4321, 32'sd0, 32'sd99);
        send_point(1'b1, 32'sh0032_0000, 32'sh0064_0000, 32'sh0001_0000, 32'sd0);
        // Integer mode with a fractional scale above one.
        load_view(1000, 700, 640, 480, 32'h0001_8000, 1'b1, 16384, 0);
        send_point(1'b0, 32'sh0010_0000, 32'sh0020_0000, 32'sd0, 32'sd0);
        send_point(1'b1, 32'sh0010_0000, 32'sh0020_0000, 32'sd0, 32'sd0);
    endtask

    task automatic test_random_settings();
        logic [31:0] vw, vh, dw, dh, zoom, cs, sn;
        int          n;
        for (int phase = 0; phase < 12; phase++) begin
            vw   = $urandom_range(1, 8192);
            vh   = $urandom_range(1, 8192);
            dw   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(1, 2048);
            dh   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(1, 2048);
            zoom = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000);
            cs   = $signed($urandom_range(0, 32768)) - 16384;
            sn   = $signed($urandom_range(0, 32768)) - 16384;
            if (phase == 0) begin
                cs = 16384;
                sn = 0;
            end
            if (phase == 11) begin
                vw = 8192; vh = 1; dw = 65535; dh = 0; zoom = 32'hffffffff;
                cs = -16384; sn = -16384;
            end
            load_view(vw, vh, dw, dh, zoom, 1'($urandom_range(0, 1)), cs, sn);
            n = 125;
            for (int k = 0; k < n; k++) begin
                steady = (phase == 5);  // one long stretch with no gaps
                random_point();
            end
            steady = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_kind     = 1'b0;
        i_point_x  = '0;
        i_point_y  = '0;
        i_center_x = '0;
        i_center_y = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        mismatches = 0;
        points_sent = 0;
        points_checked = 0;
        settings_used = 0;
        steady = 1'b0;
        view_regs = '{view_width: 14'd640, view_height: 14'd480, design_width: 16'd640,
                      design_height: 16'd480, zoom_factor: 32'd65536, whole_scale: 1'b0,
                      rotation_cosine: 16'sd16384, rotation_sine: 16'sd0};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_scale_corners();
        test_random_settings();

        i_start <= 1'b0;
        wait (expected_points.size() == 0);
        repeat (70) @(posedge i_clk);

        $display("Checked %0d of %0d points over %0d register settings.",
                 points_checked, points_sent, settings_used);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
hdl/cvt_pkg.sv
hdl/cvt_div.sv
hdl/cvt_scale.sv
hdl/camera_view_transform.sv
sim/camera_view_transform_test.sv
